// File: hdl/flvtf_pkg.sv
// flvtf_pkg: types, codes and constants of the FLV tag framer.
// Used by the channel interfaces, the parse logic and the top level.
// No dependencies.
package flvtf_pkg;

  localparam logic [7:0] SIG_F       = 8'h46;
  localparam logic [7:0] SIG_L       = 8'h4C;
  localparam logic [7:0] SIG_V       = 8'h56;
  localparam logic [7:0] TAG_AUDIO   = 8'h08;
  localparam logic [7:0] TAG_VIDEO   = 8'h09;
  localparam logic [7:0] TAG_SCRIPT  = 8'h12;
  localparam logic [3:0] FMT_AAC     = 4'hA;

  localparam logic [31:0] HDR_LEN      = 32'd9;
  localparam logic [31:0] TAG_HDR_LEN  = 32'd11;
  localparam logic [31:0] PTS_LEN      = 32'd4;
  localparam logic [31:0] OFFSET_FIRST = 32'd5;
  localparam logic [31:0] SIZE_LAST    = 32'd3;
  localparam logic [24:0] TAG_OVERHEAD = 25'd11;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_HDR_SKIP,
    PH_HDR_PTS,
    PH_TAG_HDR,
    PH_TAG_DATA,
    PH_TAG_PTS,
    PH_DISCARD
  } phase_t;

  typedef enum logic [1:0] {
    EV_HEADER,
    EV_TAG,
    EV_BAD_LEAD,
    EV_TRUNCATED
  } event_kind_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] byte_count;
    logic [31:0] header_offset;
    logic [23:0] payload_size;
    logic [7:0]  tag_type;
    logic [3:0]  audio_format;
    logic [31:0] size_acc;
  } parse_state_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [7:0]  tag_type;
    logic [23:0] data_size;
    logic [3:0]  sound_format;
    logic        is_aac;
    logic        size_ok;
    logic        packet_done;
  } result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:         PH_IDLE,
    byte_count:    32'd0,
    header_offset: 32'd0,
    payload_size:  24'd0,
    tag_type:      8'd0,
    audio_format:  4'd0,
    size_acc:      32'd0
  };

endpackage

// File: hdl/flvtf_if.sv
// flvtf_in_if / flvtf_out_if: valid/ready channels of the FLV tag framer.
// Byte channel in, event channel out. Depends on flvtf_pkg.
interface flvtf_in_if;
  import flvtf_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in_packet;

  modport source (output valid, data_byte, last_in_packet, input ready);
  modport sink   (input valid, data_byte, last_in_packet, output ready);
endinterface

interface flvtf_out_if;
  import flvtf_pkg::*;

  logic        valid;
  logic        ready;
  event_kind_t event_kind;
  logic [7:0]  tag_type;
  logic [23:0] data_size;
  logic [3:0]  sound_format;
  logic        is_aac;
  logic        size_ok;
  logic        packet_done;

  modport source (output valid, event_kind, tag_type, data_size, sound_format, is_aac,
                  size_ok, packet_done, input ready);
  modport sink   (input valid, event_kind, tag_type, data_size, sound_format, is_aac,
                  size_ok, packet_done, output ready);
endinterface

// File: hdl/flvtf_parse.sv
// flvtf_parse: next-state and event logic for one packet byte.
// Purely combinational; state is held by the top level. Depends on flvtf_pkg.
module flvtf_parse (
  input  flvtf_pkg::parse_state_t st,
  input  logic [7:0]              data_byte,
  input  logic                    last_in_packet,
  output flvtf_pkg::parse_state_t st_nxt,
  output logic                    emit,
  output flvtf_pkg::result_t      res
);
  import flvtf_pkg::*;

  logic [31:0] cnt_inc;
  logic [31:0] offset_sh;
  logic [31:0] acc_sh;
  logic [24:0] tag_expect;

  assign cnt_inc    = st.byte_count + 32'd1;
  assign offset_sh  = {st.header_offset[23:0], data_byte};
  assign acc_sh     = {st.size_acc[23:0], data_byte};
  assign tag_expect = TAG_OVERHEAD + {1'b0, st.payload_size};

  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    res    = '{event_kind: EV_HEADER, default: '0};

    unique case (st.phase)
      PH_IDLE: begin
        if (data_byte == SIG_F) begin
          st_nxt.phase         = PH_HDR;
          st_nxt.byte_count    = 32'd1;
          st_nxt.header_offset = 32'd0;
        end else if (data_byte == TAG_AUDIO || data_byte == TAG_VIDEO ||
                     data_byte == TAG_SCRIPT) begin
          st_nxt.phase        = PH_TAG_HDR;
          st_nxt.byte_count   = 32'd1;
          st_nxt.tag_type     = data_byte;
          st_nxt.payload_size = 24'd0;
          st_nxt.audio_format = 4'd0;
        end else begin
          emit            = 1'b1;
          res.event_kind  = EV_BAD_LEAD;
          res.tag_type    = data_byte;
          res.packet_done = 1'b1;
          st_nxt.phase    = PH_DISCARD;
        end
      end
      PH_HDR: begin
        if ((st.byte_count == 32'd1 && data_byte != SIG_L) ||
            (st.byte_count == 32'd2 && data_byte != SIG_V)) begin
          emit            = 1'b1;
          res.event_kind  = EV_BAD_LEAD;
          res.tag_type    = data_byte;
          res.packet_done = 1'b1;
          st_nxt.phase    = PH_DISCARD;
        end else begin
          if (st.byte_count >= OFFSET_FIRST) begin
            st_nxt.header_offset = offset_sh;
          end
          st_nxt.byte_count = cnt_inc;
          // offset is complete here: last offset byte is the ninth header byte
          if (cnt_inc == HDR_LEN) begin
            st_nxt.size_acc = 32'd0;
            if (offset_sh > HDR_LEN) begin
              st_nxt.phase = PH_HDR_SKIP;
            end else begin
              st_nxt.phase      = PH_HDR_PTS;
              st_nxt.byte_count = 32'd0;
            end
          end
        end
      end
      PH_HDR_SKIP: begin
        st_nxt.byte_count = cnt_inc;
        if (cnt_inc == st.header_offset) begin
          st_nxt.phase      = PH_HDR_PTS;
          st_nxt.byte_count = 32'd0;
        end
      end
      PH_HDR_PTS: begin
        st_nxt.size_acc   = acc_sh;
        st_nxt.byte_count = cnt_inc;
        if (cnt_inc == PTS_LEN) begin
          emit              = 1'b1;
          res.event_kind    = EV_HEADER;
          res.data_size     = st.header_offset[23:0];
          res.size_ok       = (acc_sh == 32'd0);
          st_nxt.phase      = PH_IDLE;
          st_nxt.byte_count = 32'd0;
        end
      end
      PH_TAG_HDR: begin
        if (st.byte_count <= SIZE_LAST) begin
          st_nxt.payload_size = {st.payload_size[15:0], data_byte};
        end
        st_nxt.byte_count = cnt_inc;
        if (cnt_inc == TAG_HDR_LEN) begin
          st_nxt.byte_count = 32'd0;
          st_nxt.size_acc   = 32'd0;
          st_nxt.phase      = (st.payload_size != 24'd0) ? PH_TAG_DATA : PH_TAG_PTS;
        end
      end
      PH_TAG_DATA: begin
        if (st.byte_count == 32'd0 && st.tag_type == TAG_AUDIO) begin
          st_nxt.audio_format = data_byte[7:4];
        end
        st_nxt.byte_count = cnt_inc;
        if (cnt_inc == {8'd0, st.payload_size}) begin
          st_nxt.byte_count = 32'd0;
          st_nxt.phase      = PH_TAG_PTS;
        end
      end
      PH_TAG_PTS: begin
        st_nxt.size_acc   = acc_sh;
        st_nxt.byte_count = cnt_inc;
        if (cnt_inc == PTS_LEN) begin
          emit              = 1'b1;
          res.event_kind    = EV_TAG;
          res.tag_type      = st.tag_type;
          res.data_size     = st.payload_size;
          res.sound_format  = st.audio_format;
          res.is_aac        = (st.tag_type == TAG_AUDIO) && (st.audio_format == FMT_AAC);
          res.size_ok       = (acc_sh == {7'd0, tag_expect});
          st_nxt.phase      = PH_IDLE;
          st_nxt.byte_count = 32'd0;
        end
      end
      PH_DISCARD: begin
        // drop everything until the packet ends
      end
    endcase

    if (last_in_packet) begin
      if (emit) begin
        res.packet_done = 1'b1;
      end else if (st_nxt.phase != PH_IDLE && st_nxt.phase != PH_DISCARD) begin
        emit            = 1'b1;
        res             = '{event_kind: EV_TRUNCATED, default: '0};
        res.packet_done = 1'b1;
      end
      st_nxt = STATE_RESET;
    end
  end

endmodule

// File: hdl/flv_tag_framer_core.sv
// flv_tag_framer_core: FLV header/tag framer, one packet byte per transaction.
// Depends on flvtf_pkg, flvtf_if (channels) and flvtf_parse.
//
//   channel    dir   payload                                        handshake
//   in_chan    in    data_byte[7:0], last_in_packet                 valid/ready
//   out_chan   out   event_kind, tag_type, data_size, sound_format, valid/ready
//                    is_aac, size_ok, packet_done
//
// One byte is taken every cycle; in_chan stalls only while an event is held and
// out_chan is not ready. An event appears on out_chan in the cycle after the
// byte that causes it. The parse state and the output register are the only
// storage; the path between them is one byte's worth of compare and shift logic.
// Synchronous reset returns the parser to idle and empties the output register.
module flv_tag_framer_core (
  input logic         clk,
  input logic         rst_n,
  flvtf_in_if.sink    in_chan,
  flvtf_out_if.source out_chan
);
  import flvtf_pkg::*;

  parse_state_t state_r;
  parse_state_t state_nxt;
  logic         emit;
  result_t      res;
  result_t      res_r;
  logic         out_valid_r;
  logic         accept;

  flvtf_parse u_parse (
    .st             (state_r),
    .data_byte      (in_chan.data_byte),
    .last_in_packet (in_chan.last_in_packet),
    .st_nxt         (state_nxt),
    .emit           (emit),
    .res            (res)
  );

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the event until taken; load only when a new one is produced
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.event_kind   = res_r.event_kind;
  assign out_chan.tag_type     = res_r.tag_type;
  assign out_chan.data_size    = res_r.data_size;
  assign out_chan.sound_format = res_r.sound_format;
  assign out_chan.is_aac       = res_r.is_aac;
  assign out_chan.size_ok      = res_r.size_ok;
  assign out_chan.packet_done  = res_r.packet_done;

endmodule
